// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL files of the quantizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: lbl");
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed: lbl");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- sv/rgbq_pkg.sv -----
// Package with the constants, types and quantizer function of the RGB565 quantizer.
`timescale 1ns / 1ps
`default_nettype none
package rgbq_pkg;

  localparam int CAMERA_WIDTH  = 96;
  localparam int CAMERA_HEIGHT = 96;
  localparam int TARGET_WIDTH  = 96;
  localparam int TARGET_HEIGHT = 96;

  localparam int COL_W = (CAMERA_WIDTH > 1) ? $clog2(CAMERA_WIDTH) : 1;
  localparam int ROW_W = (CAMERA_HEIGHT > 1) ? $clog2(CAMERA_HEIGHT) : 1;
  localparam int OFFSET_W = 14;
  localparam int LEFT_MARGIN = (TARGET_WIDTH - CAMERA_WIDTH) / 2;
  localparam int TOP_MARGIN  = (TARGET_HEIGHT - CAMERA_HEIGHT) / 2;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [5:0] RB_CENTER = 6'd16;
  localparam logic [5:0] G_CENTER  = 6'd32;
  localparam logic [2:0] RB_EXTRA  = 3'd4;
  localparam logic [2:0] G_EXTRA   = 3'd5;

  localparam logic [31:0] MULT_RESET  = 32'd128;
  localparam logic [4:0]  SHIFT_RESET = 5'd7;
  localparam logic [7:0]  ZP_RESET    = 8'd0;

  localparam logic signed [7:0] Q_MAX = 8'sh7f;
  localparam logic signed [7:0] Q_MIN = -8'sd128;

  typedef enum logic [1:0] {
    REG_MULT  = 2'd0,
    REG_SHIFT = 2'd1,
    REG_ZP    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [31:0]        mult;
    logic [4:0]         shift;
    logic signed [7:0]  zp;
  } cfg_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic                last;
  } pos_info_t;

  function automatic logic signed [7:0] quantize(input logic [5:0] level,
                                                 input logic [5:0] center,
                                                 input logic [2:0] extra,
                                                 input cfg_t cfg);
    logic               neg;
    logic [5:0]         delta;
    logic [37:0]        prod;
    logic [5:0]         sh;
    logic [37:0]        mag;
    logic signed [9:0]  sval;
    logic signed [9:0]  sum;
    logic signed [7:0]  res;
    neg   = level < center;
    delta = neg ? (center - level) : (level - center);
    prod  = 38'(delta) * 38'(cfg.mult);
    sh    = 6'(cfg.shift) + 6'(extra);
    mag   = prod >> sh;
    sval  = $signed({2'b00, mag[7:0]});
    if (neg) begin
      sval = -sval;
    end
    sum = sval + $signed({{2{cfg.zp[7]}}, cfg.zp});
    if (|mag[37:8]) begin
      res = neg ? Q_MIN : Q_MAX;
    end else if (sum > 10'sd127) begin
      res = Q_MAX;
    end else if (sum < -10'sd128) begin
      res = Q_MIN;
    end else begin
      res = sum[7:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- sv/rgbq_cfg_regs.sv -----
// APB configuration registers for multiplier, shift and zero point.
`timescale 1ns / 1ps
`default_nettype none
module rgbq_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rgbq_pkg::ADDR_W-1:0] paddr,
  input  logic [rgbq_pkg::DATA_W-1:0] pwdata,
  output logic [rgbq_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output rgbq_pkg::cfg_t              cfg
);
  import rgbq_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mult  <= MULT_RESET;
      cfg.shift <= SHIFT_RESET;
      cfg.zp    <= ZP_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_MULT:  cfg.mult  <= pwdata;
        REG_SHIFT: cfg.shift <= pwdata[4:0];
        REG_ZP:    cfg.zp    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MULT:  prdata = cfg.mult;
      REG_SHIFT: prdata = {27'b0, cfg.shift};
      REG_ZP:    prdata = {{24{cfg.zp[7]}}, cfg.zp};
      default:   prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

// ----- sv/rgbq_position.sv -----
// Raster position tracker that yields the planar offset and the frame end flag.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rgbq_position (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                new_frame,
  output rgbq_pkg::pos_info_t info
);
  import rgbq_pkg::*;

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic             col_last;
  logic             row_last;
  logic [31:0]      off_full;

  assign cur_col  = new_frame ? '0 : col;
  assign cur_row  = new_frame ? '0 : row;
  assign col_last = cur_col == COL_W'(CAMERA_WIDTH - 1);
  assign row_last = cur_row == ROW_W'(CAMERA_HEIGHT - 1);

  always_comb begin
    col_next = cur_col + 1'b1;
    row_next = cur_row;
    if (col_last) begin
      col_next = '0;
      row_next = row_last ? '0 : cur_row + 1'b1;
    end
  end

  assign off_full = (32'(TOP_MARGIN) + 32'(cur_row)) * 32'(TARGET_WIDTH)
                  + 32'(LEFT_MARGIN) + 32'(cur_col);

  assign info.offset = off_full[OFFSET_W-1:0];
  assign info.last   = col_last && row_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  `ASSERT_CLK(col_in_range, clk, rst, col <= COL_W'(CAMERA_WIDTH - 1))
  `ASSERT_CLK(row_in_range, clk, rst, row <= ROW_W'(CAMERA_HEIGHT - 1))
  `ASSERT_CLK(wrap_after_last, clk, rst, (accept && info.last) |=> (col == '0 && row == '0))
endmodule
`default_nettype wire

// ----- sv/rgbq_quant.sv -----
// Quantizer stage with the result register for the three channels.
`timescale 1ns / 1ps
`default_nettype none
module rgbq_quant (
  input  logic                           clk,
  input  logic                           load,
  input  rgbq_pkg::cfg_t                 cfg,
  input  logic [15:0]                    word,
  input  rgbq_pkg::pos_info_t            info,
  input  logic                           chunk,
  output logic [rgbq_pkg::OFFSET_W-1:0]  plane_offset,
  output logic signed [7:0]              red_q,
  output logic signed [7:0]              green_q,
  output logic signed [7:0]              blue_q,
  output logic                           chunk_end,
  output logic                           frame_end
);
  import rgbq_pkg::*;

  logic signed [7:0] red_next;
  logic signed [7:0] green_next;
  logic signed [7:0] blue_next;

  assign red_next   = quantize({1'b0, word[15:11]}, RB_CENTER, RB_EXTRA, cfg);
  assign green_next = quantize(word[10:5], G_CENTER, G_EXTRA, cfg);
  assign blue_next  = quantize({1'b0, word[4:0]}, RB_CENTER, RB_EXTRA, cfg);

  always_ff @(posedge clk) begin
    if (load) begin
      plane_offset <= info.offset;
      red_q        <= red_next;
      green_q      <= green_next;
      blue_q       <= blue_next;
      chunk_end    <= chunk;
      frame_end    <= info.last;
    end
  end
endmodule
`default_nettype wire

// ----- sv/rgb565_to_int8_planar_quantizer_unit.sv -----
// Top level: RGB565 pixel stream to saturated int8 planar values with offset.
// An accepted input transaction passes through the input register and then the result register to out_valid.
// Throughput is one pixel per cycle while out_ready stays high, set by the input register and the result register.
// Each stage loads when it is empty or its contents move on, so stalls cost no bubbles.
// Synchronous reset empties both stages, sets the position to row 0 column 0
// and loads the registers with multiplier 128, shift 7 and zero point 0.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rgb565_to_int8_planar_quantizer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rgbq_pkg::ADDR_W-1:0]    paddr,
  input  logic [rgbq_pkg::DATA_W-1:0]    pwdata,
  output logic [rgbq_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [15:0]                    rgb_word,
  input  logic                           new_frame,
  input  logic                           chunk_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rgbq_pkg::OFFSET_W-1:0]  plane_offset,
  output logic signed [7:0]              red_q,
  output logic signed [7:0]              green_q,
  output logic signed [7:0]              blue_q,
  output logic                           chunk_end,
  output logic                           frame_end
);
  import rgbq_pkg::*;

  cfg_t      cfg;
  pos_info_t info;
  pos_info_t s1_info;
  logic      s1_valid;
  logic [15:0] s1_word;
  logic      s1_chunk;
  logic      in_accept;
  logic      out_load;

  assign out_load  = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || out_load;
  assign in_accept = in_valid && in_ready;

  rgbq_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rgbq_position u_pos (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .new_frame (new_frame),
    .info      (info)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_word  <= rgb_word;
      s1_info  <= info;
      s1_chunk <= chunk_last;
    end
  end

  rgbq_quant u_quant (
    .clk          (clk),
    .load         (out_load),
    .cfg          (cfg),
    .word         (s1_word),
    .info         (s1_info),
    .chunk        (s1_chunk),
    .plane_offset (plane_offset),
    .red_q        (red_q),
    .green_q      (green_q),
    .blue_q       (blue_q),
    .chunk_end    (chunk_end),
    .frame_end    (frame_end)
  );

  `ASSERT_CLK(accept_fills_stage, clk, rst, in_accept |=> s1_valid)
  `ASSERT_CLK(result_from_stage, clk, rst, $rose(out_valid) |-> $past(s1_valid))
  `ASSERT_CLK(result_held, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(plane_offset) && $stable(red_q)))
endmodule
`default_nettype wire

// ----- dv/rgb565_to_int8_planar_quantizer_unit_tb.sv -----
// Self-checking testbench for the RGB565 to int8 planar quantizer unit.
`timescale 1ns / 1ps
`default_nettype none
module rgb565_to_int8_planar_quantizer_unit_tb;
  import rgbq_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int IDLE_PCT = 11;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_RUN = 250;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic signed [7:0]   red;
    logic signed [7:0]   green;
    logic signed [7:0]   blue;
    logic                chunk;
    logic                frame;
  } pixel_result_t;

  typedef struct packed {
    logic [15:0]   rgb;
    logic          restart;
    logic          last;
    logic          typed;
    pixel_result_t want;
  } pixel_row_t;

  localparam pixel_row_t PIXEL_TABLE [0:15] = '{
    '{16'h0000, 1'b1, 1'b0, 1'b1, '{14'd0, -8'sd1, -8'sd1, -8'sd1, 1'b0, 1'b0}},
    '{16'hffff, 1'b0, 1'b1, 1'b1, '{14'd1, 8'sd0, 8'sd0, 8'sd0, 1'b1, 1'b0}},
    '{16'h8410, 1'b0, 1'b0, 1'b1, '{14'd2, 8'sd0, 8'sd0, 8'sd0, 1'b0, 1'b0}},
    '{16'hf800, 1'b0, 1'b0, 1'b1, '{14'd3, 8'sd0, -8'sd1, -8'sd1, 1'b0, 1'b0}},
    '{16'h07e0, 1'b0, 1'b0, 1'b1, '{14'd4, -8'sd1, 8'sd0, -8'sd1, 1'b0, 1'b0}},
    '{16'h001f, 1'b0, 1'b1, 1'b1, '{14'd5, -8'sd1, -8'sd1, 8'sd0, 1'b1, 1'b0}},
    '{16'h7bef, 1'b0, 1'b0, 1'b1, '{14'd6, 8'sd0, 8'sd0, 8'sd0, 1'b0, 1'b0}},
    '{16'h1234, 1'b1, 1'b1, 1'b0, '0},
    '{16'ha5a5, 1'b0, 1'b0, 1'b0, '0},
    '{16'h5a5a, 1'b0, 1'b1, 1'b0, '0},
    '{16'h0001, 1'b0, 1'b0, 1'b0, '0},
    '{16'h0800, 1'b0, 1'b0, 1'b0, '0},
    '{16'h0020, 1'b0, 1'b0, 1'b0, '0},
    '{16'h8000, 1'b0, 1'b1, 1'b0, '0},
    '{16'h4210, 1'b1, 1'b0, 1'b0, '0},
    '{16'hc618, 1'b0, 1'b0, 1'b0, '0}
  };

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [DATA_W-1:0]     pwdata = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [15:0]           rgb_word = '0;
  logic                  new_frame = 1'b0;
  logic                  chunk_last = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OFFSET_W-1:0]   plane_offset;
  logic signed [7:0]     red_q;
  logic signed [7:0]     green_q;
  logic signed [7:0]     blue_q;
  logic                  chunk_end;
  logic                  frame_end;

  logic [31:0]           mult_mirror = MULT_RESET;
  logic [4:0]            shift_mirror = SHIFT_RESET;
  logic signed [7:0]     zp_mirror = ZP_RESET;
  int unsigned           column_at = 0;
  int unsigned           row_at = 0;

  pixel_result_t         expected_pixels[$];
  int                    stall_pct = IDLE_PCT;
  int                    error_count = 0;
  int                    pixels_sent = 0;
  int                    pixels_checked = 0;
  int                    frame_ends_seen = 0;
  int                    settings_used = 1;
  int                    cycle_count = 0;

  rgb565_to_int8_planar_quantizer_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rgb_word     (rgb_word),
    .new_frame    (new_frame),
    .chunk_last   (chunk_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .plane_offset (plane_offset),
    .red_q        (red_q),
    .green_q      (green_q),
    .blue_q       (blue_q),
    .chunk_end    (chunk_end),
    .frame_end    (frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic signed [7:0] scale_level(input int unsigned level,
                                                    input int unsigned center,
                                                    input int unsigned extra);
    longint unsigned delta;
    longint unsigned mag;
    longint          q;
    bit              below;
    below = level < center;
    delta = below ? longint'(center - level) : longint'(level - center);
    mag   = (delta * {32'd0, mult_mirror}) >> (int'(shift_mirror) + extra);
    q     = below ? -longint'(mag) : longint'(mag);
    q     = q + longint'(zp_mirror);
    if (q > 127) begin
      q = 127;
    end
    if (q < -128) begin
      q = -128;
    end
    return q[7:0];
  endfunction

  function automatic pixel_result_t quantize_pixel(input logic [15:0] rgb, input logic restart,
                                                   input logic last);
    pixel_result_t res;
    int            offset;
    if (restart) begin
      column_at = 0;
      row_at = 0;
    end
    offset = (TOP_MARGIN + int'(row_at)) * TARGET_WIDTH + LEFT_MARGIN + int'(column_at);
    res.offset = offset[OFFSET_W-1:0];
    res.red    = scale_level(rgb[15:11], 16, 4);
    res.green  = scale_level(rgb[10:5], 32, 5);
    res.blue   = scale_level(rgb[4:0], 16, 4);
    res.chunk  = last;
    res.frame  = (column_at == CAMERA_WIDTH - 1) && (row_at == CAMERA_HEIGHT - 1);
    column_at++;
    if (column_at >= CAMERA_WIDTH) begin
      column_at = 0;
      row_at++;
      if (row_at >= CAMERA_HEIGHT) begin
        row_at = 0;
      end
    end
    return res;
  endfunction

  function automatic logic [5:0] corner_level(input int unsigned center);
    logic [5:0] level;
    case ($urandom_range(4))
      0: level = 6'd0;
      1: level = 6'(center - 1);
      2: level = 6'(center);
      3: level = 6'(center + 1);
      default: level = 6'(2 * center - 1);
    endcase
    return level;
  endfunction

  function automatic logic [15:0] random_rgb();
    logic [5:0] r;
    logic [5:0] g;
    logic [5:0] b;
    if ($urandom_range(3) == 0) begin
      r = corner_level(16);
      g = corner_level(32);
      b = corner_level(16);
      return {r[4:0], g, b[4:0]};
    end
    return 16'($urandom);
  endfunction

  task automatic send_pixel(input logic [15:0] rgb, input logic restart, input logic last,
                            input logic typed, input pixel_result_t want);
    pixel_result_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < stall_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    rgb_word   <= rgb;
    new_frame  <= restart;
    chunk_last <= last;
    do @(posedge clk); while (!in_ready);
    predicted = quantize_pixel(rgb, restart, last);
    expected_pixels.push_back(typed ? want : predicted);
    pixels_sent++;
  endtask

  task automatic drain_pixels();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MULT:  mult_mirror = data;
      REG_SHIFT: shift_mirror = data[4:0];
      REG_ZP:    zp_mirror = data[7:0];
      default: ;
    endcase
  endtask

  task automatic program_scale(input logic [31:0] mult, input logic [4:0] shift,
                               input logic [7:0] zp);
    drain_pixels();
    apb_write(REG_MULT, mult);
    apb_write(REG_SHIFT, {27'd0, shift});
    apb_write(REG_ZP, {24'd0, zp});
    settings_used++;
  endtask

  task automatic stream_pixels(input int count);
    for (int n = 0; n < count; n++) begin
      send_pixel(random_rgb(), $urandom_range(99) == 0, $urandom_range(7) == 0, 1'b0, '0);
    end
  endtask

  task automatic compare_pixel(input pixel_result_t want);
    if (plane_offset !== want.offset) begin
      $error("plane_offset: expected %0d, got %0d", want.offset, plane_offset);
      error_count++;
    end
    if (red_q !== want.red) begin
      $error("red_q: expected %0d, got %0d", want.red, red_q);
      error_count++;
    end
    if (green_q !== want.green) begin
      $error("green_q: expected %0d, got %0d", want.green, green_q);
      error_count++;
    end
    if (blue_q !== want.blue) begin
      $error("blue_q: expected %0d, got %0d", want.blue, blue_q);
      error_count++;
    end
    if (chunk_end !== want.chunk) begin
      $error("chunk_end: expected %0d, got %0d", want.chunk, chunk_end);
      error_count++;
    end
    if (frame_end !== want.frame) begin
      $error("frame_end: expected %0d, got %0d", want.frame, frame_end);
      error_count++;
    end
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected output transaction, offset %0d", plane_offset);
        error_count++;
      end else begin
        compare_pixel(expected_pixels.pop_front());
        pixels_checked++;
        if (frame_end === 1'b1) begin
          frame_ends_seen++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL rgb565_to_int8_planar_quantizer_unit");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A write to the spare register index must leave the reset scale untouched.
    apb_write(REG_SPARE, 32'hffff_ffff);
    for (int n = 0; n < $size(PIXEL_TABLE); n++) begin
      send_pixel(PIXEL_TABLE[n].rgb, PIXEL_TABLE[n].restart, PIXEL_TABLE[n].last,
                 PIXEL_TABLE[n].typed, PIXEL_TABLE[n].want);
    end

    program_scale(32'd0, 5'd0, 8'd127);
    stream_pixels(100);
    program_scale(32'hffff_ffff, 5'd0, 8'd0);
    stream_pixels(120);
    program_scale(32'hffff_ffff, 5'd31, 8'h80);
    stream_pixels(120);
    program_scale(32'd1, 5'd0, 8'd100);
    stream_pixels(100);
    for (int n = 0; n < 3; n++) begin
      program_scale($urandom_range(1) ? $urandom : $urandom_range(4095),
                    5'($urandom_range(31)), 8'($urandom_range(255)));
      stream_pixels(100);
    end

    // Long stretch at the reset scale with one restart at its start; the first
    // half runs with no idling on either side.
    program_scale(MULT_RESET, SHIFT_RESET, ZP_RESET);
    stall_pct = 0;
    send_pixel(random_rgb(), 1'b1, 1'b0, 1'b0, '0);
    for (int n = 1; n < LONG_RUN; n++) begin
      if (n == LONG_RUN / 2) begin
        stall_pct = IDLE_PCT;
      end
      send_pixel(random_rgb(), 1'b0, $urandom_range(7) == 0, 1'b0, '0);
    end

    drain_pixels();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d pixel transactions (%0d checked) under %0d scale settings.",
             pixels_sent, pixels_checked, settings_used);
    $display("Frame ends observed: %0d; errors: %0d.", frame_ends_seen, error_count);
    if (error_count == 0) begin
      $display("PASS rgb565_to_int8_planar_quantizer_unit");
    end else begin
      $display("FAIL rgb565_to_int8_planar_quantizer_unit");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- rgb565_to_int8_planar_quantizer_unit.f -----
+incdir+sv
sv/rgbq_pkg.sv
sv/rgbq_cfg_regs.sv
sv/rgbq_position.sv
sv/rgbq_quant.sv
sv/rgb565_to_int8_planar_quantizer_unit.sv
dv/rgb565_to_int8_planar_quantizer_unit_tb.sv
